FILE: rtl/sdspi_pkg.sv
// ============================================================================
// sdspi_pkg
// Shared types and constants for the SD SPI-mode block transfer controller.
// ============================================================================
`default_nettype none

package sdspi_pkg;

   // Request kinds, carried on req_tuser
   typedef enum logic [2:0] {
      OP_INIT  = 3'd0,
      OP_WRITE = 3'd1,
      OP_READ  = 3'd2,
      OP_XCHG  = 3'd3,
      OP_LOAD  = 3'd4,
      OP_FETCH = 3'd5
   } opcode_type;

   // Completion status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOT_IDLE = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_CRC_ERR  = 3'd3;
   localparam logic [2:0] ST_BAD_RESP = 3'd4;

   // Command framing
   localparam logic [7:0]  CMD_PREFIX = 8'h40;
   localparam logic [7:0]  CMD0_CODE  = 8'h00;
   localparam logic [7:0]  CMD1_CODE  = 8'h01;
   localparam logic [7:0]  CMD24_CODE = 8'h18;
   localparam logic [7:0]  CMD17_CODE = 8'h11;
   localparam logic [7:0]  CMD0_CRC   = 8'h95;
   localparam logic [31:0] CMD1_ARG   = 32'h00ff_c000;

   // Line bytes and card responses
   localparam logic [7:0] FILL_BYTE   = 8'hff;
   localparam logic [7:0] START_TOKEN = 8'hfe;
   localparam logic [7:0] R1_READY    = 8'h00;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [3:0] NIB_MASK    = 4'h0f;
   localparam logic [3:0] DR_ACCEPTED = 4'h5;
   localparam logic [3:0] DR_CRC_ERR  = 4'hb;

   // Sequencer phases, one-hot
   typedef enum logic [22:0] {
      PH_IDLE     = 23'h000001,
      PH_CLK      = 23'h000002,
      PH_CMD0     = 23'h000004,
      PH_POLL0    = 23'h000008,
      PH_PRE1     = 23'h000010,
      PH_CMD1     = 23'h000020,
      PH_POLL1    = 23'h000040,
      PH_INIT_END = 23'h000080,
      PH_CMD24    = 23'h000100,
      PH_POLL24   = 23'h000200,
      PH_W_GAP    = 23'h000400,
      PH_W_TOKEN  = 23'h000800,
      PH_W_DATA   = 23'h001000,
      PH_W_CRC    = 23'h002000,
      PH_W_RESP   = 23'h004000,
      PH_W_BUSY   = 23'h008000,
      PH_W_END    = 23'h010000,
      PH_CMD17    = 23'h020000,
      PH_POLL17   = 23'h040000,
      PH_R_WAIT   = 23'h080000,
      PH_R_DATA   = 23'h100000,
      PH_R_CRC    = 23'h200000,
      PH_R_END    = 23'h400000
   } phase_type;

   // Registered result; byte fields may be replaced by buffer read data
   typedef struct packed {
      logic       drive_valid;
      logic [7:0] drive_byte;
      logic       drive_from_buf;
      logic       select_high;
      logic       op_done;
      logic [2:0] result_status;
      logic       fetch_from_buf;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/sd_spi_block_transfer_controller_unit.sv
// ============================================================================
// sd_spi_block_transfer_controller_unit
// SD card host in SPI mode, sequenced one byte slot per request.
// Result: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the only storage
// in the path is the result register and the buffer's registered read port.
// Reset: synchronous; the sequencer returns to idle, counters clear, the
// result register empties. Buffer contents are not cleared.
// ============================================================================
`default_nettype none

module sd_spi_block_transfer_controller_unit #(
   parameter int BLOCK_BYTES      = 512,
   parameter int INIT_CLOCK_BYTES = 10,
   parameter int POLL_TRIES       = 9
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] card_address, [41:32] read_length, [50:42] buffer_index,
   // [58:51] buffer_byte, [66:59] card_byte, [71:67] zero
   input  wire logic [71:0] req_tdata,
   // [2:0] opcode
   input  wire logic [2:0]  req_tuser,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] drive_valid, [8:1] drive_byte, [9] select_high, [10] op_done,
   // [13:11] result_status, [21:14] fetched_byte, [23:22] zero
   output logic [23:0]      rsp_tdata
);

   localparam int AW     = $clog2(BLOCK_BYTES);
   localparam int CNT_A  = $clog2(BLOCK_BYTES + 1);
   localparam int CNT_B  = $clog2(INIT_CLOCK_BYTES + 1);
   localparam int CNT_W  = (CNT_A > CNT_B) ? CNT_A : CNT_B;
   localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;
   localparam int PC_W   = $clog2(POLL_TRIES + 1);

   // slot counts inside a phase
   localparam logic [CNT_W-1:0] CMD_SLOTS = CNT_W'(6);
   localparam logic [CNT_W-1:0] GAP_SLOTS = CNT_W'(3);
   localparam logic [CNT_W-1:0] CRC_SLOTS = CNT_W'(2);
   localparam logic [CNT_W-1:0] BLK_CNT   = CNT_W'(BLOCK_BYTES);
   localparam logic [CNT_W-1:0] CLK_CNT   = CNT_W'(INIT_CLOCK_BYTES);
   localparam logic [CMP_W-1:0] BLK_CMP   = CMP_W'(BLOCK_BYTES);
   localparam logic [PC_W-1:0]  POLL_MAX  = PC_W'(POLL_TRIES);

   // ---------------------------------------------------------------- fields
   logic [31:0] in_address;
   logic [9:0]  in_length;
   logic [8:0]  in_index;
   logic [7:0]  in_buf_byte;
   logic [7:0]  in_card_byte;
   sdspi_pkg::opcode_type in_op;

   assign in_address   = req_tdata[31:0];
   assign in_length    = req_tdata[41:32];
   assign in_index     = req_tdata[50:42];
   assign in_buf_byte  = req_tdata[58:51];
   assign in_card_byte = req_tdata[66:59];
   assign in_op        = sdspi_pkg::opcode_type'(req_tuser);

   // ---------------------------------------------------------------- state
   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]     byte_count_ff, byte_count_in;
   logic [PC_W-1:0]      poll_count_ff, poll_count_in;
   logic [31:0]          saved_address_ff, saved_address_in;
   logic [CNT_W-1:0]     saved_length_ff, saved_length_in;
   logic [3:0]           resp_nibble_ff, resp_nibble_in;

   sdspi_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 out_valid_ff;

   // buffer ports, before gating by accept
   logic          buf_we, buf_re;
   logic [AW-1:0] buf_waddr, buf_raddr;
   logic [7:0]    buf_wdata, buf_rdata;

   logic             accept;
   logic [CNT_W-1:0] count_inc;
   logic [CMP_W-1:0] len_ext;
   logic             index_ok;

   // output stage frees up whenever its result is taken
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign count_inc  = byte_count_ff + CNT_W'(1);
   assign len_ext    = CMP_W'(in_length);
   assign index_ok   = CMP_W'(in_index) < BLK_CMP;

   // ---------------------------------------------------------------- helpers
   function automatic sdspi_pkg::rsp_type slot(logic [7:0] b, logic cs_high);
      sdspi_pkg::rsp_type r;
      r             = '0;
      r.drive_valid = 1'b1;
      r.drive_byte  = b;
      r.select_high = cs_high;
      return r;
   endfunction

   function automatic sdspi_pkg::rsp_type done(logic [2:0] status);
      sdspi_pkg::rsp_type r;
      r               = '0;
      r.op_done       = 1'b1;
      r.result_status = status;
      return r;
   endfunction

   // byte n of a six-byte command frame: code, argument MSB first, CRC
   function automatic logic [7:0] cmd_byte(sdspi_pkg::phase_type ph, logic [2:0] n,
                                           logic [31:0] addr);
      logic [7:0]  code;
      logic [31:0] arg;
      logic [7:0]  crc;
      logic [7:0]  b;
      code = sdspi_pkg::CMD17_CODE;
      arg  = addr;
      crc  = sdspi_pkg::FILL_BYTE;
      case (ph)
         sdspi_pkg::PH_CMD0: begin
            code = sdspi_pkg::CMD0_CODE;
            arg  = 32'h0;
            crc  = sdspi_pkg::CMD0_CRC;
         end
         sdspi_pkg::PH_CMD1: begin
            code = sdspi_pkg::CMD1_CODE;
            arg  = sdspi_pkg::CMD1_ARG;
         end
         sdspi_pkg::PH_CMD24: begin
            code = sdspi_pkg::CMD24_CODE;
         end
         default: begin
         end
      endcase
      case (n)
         3'd0:    b = code | sdspi_pkg::CMD_PREFIX;
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         default: b = crc;
      endcase
      return b;
   endfunction

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      poll_count_in    = poll_count_ff;
      saved_address_in = saved_address_ff;
      saved_length_in  = saved_length_ff;
      resp_nibble_in   = resp_nibble_ff;
      rsp_in           = '0;
      buf_we           = 1'b0;
      buf_waddr        = AW'(in_index);
      buf_wdata        = in_buf_byte;
      buf_re           = 1'b0;
      buf_raddr        = AW'(in_index);

      case (in_op)
         sdspi_pkg::OP_INIT: begin
            phase_in      = sdspi_pkg::PH_CLK;
            byte_count_in = CNT_W'(1);
            rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
         end
         sdspi_pkg::OP_WRITE: begin
            saved_address_in = in_address;
            phase_in         = sdspi_pkg::PH_CMD24;
            byte_count_in    = CNT_W'(1);
            rsp_in = slot(cmd_byte(sdspi_pkg::PH_CMD24, 3'd0, in_address), 1'b0);
         end
         sdspi_pkg::OP_READ: begin
            saved_address_in = in_address;
            saved_length_in  = (len_ext > BLK_CMP) ? BLK_CNT : CNT_W'(len_ext);
            phase_in         = sdspi_pkg::PH_CMD17;
            byte_count_in    = CNT_W'(1);
            rsp_in = slot(cmd_byte(sdspi_pkg::PH_CMD17, 3'd0, in_address), 1'b0);
         end
         sdspi_pkg::OP_LOAD: begin
            buf_we = index_ok;
         end
         sdspi_pkg::OP_FETCH: begin
            buf_re                = index_ok;
            rsp_in.fetch_from_buf = index_ok;
         end
         sdspi_pkg::OP_XCHG: begin
            case (phase_ff)
               sdspi_pkg::PH_CLK: begin
                  if (byte_count_ff < CLK_CNT) begin
                     byte_count_in = count_inc;
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
                  end else begin
                     phase_in      = sdspi_pkg::PH_CMD0;
                     byte_count_in = CNT_W'(1);
                     rsp_in = slot(cmd_byte(sdspi_pkg::PH_CMD0, 3'd0, saved_address_ff),
                                   1'b0);
                  end
               end
               sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD1,
               sdspi_pkg::PH_CMD24, sdspi_pkg::PH_CMD17: begin
                  if (byte_count_ff < CMD_SLOTS) begin
                     byte_count_in = count_inc;
                     rsp_in = slot(cmd_byte(phase_ff, byte_count_ff[2:0], saved_address_ff),
                                   1'b0);
                  end else begin
                     case (phase_ff)
                        sdspi_pkg::PH_CMD0:  phase_in = sdspi_pkg::PH_POLL0;
                        sdspi_pkg::PH_CMD1:  phase_in = sdspi_pkg::PH_POLL1;
                        sdspi_pkg::PH_CMD24: phase_in = sdspi_pkg::PH_POLL24;
                        default:             phase_in = sdspi_pkg::PH_POLL17;
                     endcase
                     poll_count_in = PC_W'(1);
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end
               end
               sdspi_pkg::PH_POLL0, sdspi_pkg::PH_POLL1,
               sdspi_pkg::PH_POLL24, sdspi_pkg::PH_POLL17: begin
                  if (in_card_byte == sdspi_pkg::R1_READY ||
                      in_card_byte == sdspi_pkg::R1_IDLE || poll_count_ff >= POLL_MAX) begin
                     // last polled byte is the response
                     case (phase_ff)
                        sdspi_pkg::PH_POLL0: begin
                           if (in_card_byte != sdspi_pkg::R1_IDLE) begin
                              phase_in = sdspi_pkg::PH_IDLE;
                              rsp_in   = done(sdspi_pkg::ST_NOT_IDLE);
                           end else begin
                              phase_in      = sdspi_pkg::PH_PRE1;
                              byte_count_in = '0;
                              rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
                           end
                        end
                        sdspi_pkg::PH_POLL1: begin
                           phase_in = (in_card_byte == sdspi_pkg::R1_IDLE) ?
                                      sdspi_pkg::PH_PRE1 : sdspi_pkg::PH_INIT_END;
                           byte_count_in = '0;
                           rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
                        end
                        sdspi_pkg::PH_POLL24: begin
                           if (in_card_byte != sdspi_pkg::R1_READY) begin
                              phase_in = sdspi_pkg::PH_IDLE;
                              rsp_in   = done(sdspi_pkg::ST_REJECTED);
                           end else begin
                              phase_in      = sdspi_pkg::PH_W_GAP;
                              byte_count_in = CNT_W'(1);
                              rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                           end
                        end
                        default: begin
                           if (in_card_byte != sdspi_pkg::R1_READY) begin
                              phase_in = sdspi_pkg::PH_IDLE;
                              rsp_in   = done(sdspi_pkg::ST_REJECTED);
                           end else begin
                              phase_in      = sdspi_pkg::PH_R_WAIT;
                              byte_count_in = '0;
                              rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                           end
                        end
                     endcase
                  end else begin
                     poll_count_in = poll_count_ff + PC_W'(1);
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end
               end
               sdspi_pkg::PH_PRE1: begin
                  phase_in      = sdspi_pkg::PH_CMD1;
                  byte_count_in = CNT_W'(1);
                  rsp_in = slot(cmd_byte(sdspi_pkg::PH_CMD1, 3'd0, saved_address_ff), 1'b0);
               end
               sdspi_pkg::PH_INIT_END, sdspi_pkg::PH_R_END: begin
                  phase_in = sdspi_pkg::PH_IDLE;
                  rsp_in   = done(sdspi_pkg::ST_OK);
               end
               sdspi_pkg::PH_W_GAP: begin
                  if (byte_count_ff < GAP_SLOTS) begin
                     byte_count_in = count_inc;
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end else begin
                     phase_in      = sdspi_pkg::PH_W_TOKEN;
                     byte_count_in = '0;
                     rsp_in        = slot(sdspi_pkg::START_TOKEN, 1'b0);
                  end
               end
               sdspi_pkg::PH_W_TOKEN: begin
                  phase_in              = sdspi_pkg::PH_W_DATA;
                  byte_count_in         = CNT_W'(1);
                  buf_re                = 1'b1;
                  buf_raddr             = '0;
                  rsp_in                = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  rsp_in.drive_from_buf = 1'b1;
               end
               sdspi_pkg::PH_W_DATA: begin
                  if (byte_count_ff < BLK_CNT) begin
                     byte_count_in         = count_inc;
                     buf_re                = 1'b1;
                     buf_raddr             = AW'(byte_count_ff);
                     rsp_in                = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                     rsp_in.drive_from_buf = 1'b1;
                  end else begin
                     phase_in      = sdspi_pkg::PH_W_CRC;
                     byte_count_in = CNT_W'(1);
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end
               end
               sdspi_pkg::PH_W_CRC: begin
                  if (byte_count_ff < CRC_SLOTS) begin
                     byte_count_in = count_inc;
                  end else begin
                     phase_in      = sdspi_pkg::PH_W_RESP;
                     byte_count_in = '0;
                  end
                  rsp_in = slot(sdspi_pkg::FILL_BYTE, 1'b0);
               end
               sdspi_pkg::PH_W_RESP: begin
                  resp_nibble_in = in_card_byte[3:0] & sdspi_pkg::NIB_MASK;
                  phase_in       = sdspi_pkg::PH_W_BUSY;
                  byte_count_in  = '0;
                  rsp_in         = slot(sdspi_pkg::FILL_BYTE, 1'b0);
               end
               sdspi_pkg::PH_W_BUSY: begin
                  // card holds the line low while programming
                  if (in_card_byte == 8'h00) begin
                     rsp_in = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end else begin
                     phase_in      = sdspi_pkg::PH_W_END;
                     byte_count_in = '0;
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
                  end
               end
               sdspi_pkg::PH_W_END: begin
                  phase_in = sdspi_pkg::PH_IDLE;
                  if (resp_nibble_ff == sdspi_pkg::DR_ACCEPTED) begin
                     rsp_in = done(sdspi_pkg::ST_OK);
                  end else if (resp_nibble_ff == sdspi_pkg::DR_CRC_ERR) begin
                     rsp_in = done(sdspi_pkg::ST_CRC_ERR);
                  end else begin
                     rsp_in = done(sdspi_pkg::ST_BAD_RESP);
                  end
               end
               sdspi_pkg::PH_R_WAIT: begin
                  rsp_in = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  if (in_card_byte == sdspi_pkg::START_TOKEN) begin
                     if (saved_length_ff != '0) begin
                        phase_in      = sdspi_pkg::PH_R_DATA;
                        byte_count_in = '0;
                     end else begin
                        phase_in      = sdspi_pkg::PH_R_CRC;
                        byte_count_in = CNT_W'(1);
                     end
                  end
               end
               sdspi_pkg::PH_R_DATA: begin
                  buf_we        = byte_count_ff < BLK_CNT;
                  buf_waddr     = AW'(byte_count_ff);
                  buf_wdata     = in_card_byte;
                  byte_count_in = count_inc;
                  rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  if (!(count_inc < saved_length_ff)) begin
                     phase_in      = sdspi_pkg::PH_R_CRC;
                     byte_count_in = CNT_W'(1);
                  end
               end
               sdspi_pkg::PH_R_CRC: begin
                  if (byte_count_ff < CRC_SLOTS) begin
                     byte_count_in = count_inc;
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b0);
                  end else begin
                     phase_in      = sdspi_pkg::PH_R_END;
                     byte_count_in = '0;
                     rsp_in        = slot(sdspi_pkg::FILL_BYTE, 1'b1);
                  end
               end
               default: begin
                  // idle: exchange has no effect
               end
            endcase
         end
         default: begin
            // unused opcodes are ignored
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= sdspi_pkg::PH_IDLE;
         byte_count_ff    <= '0;
         poll_count_ff    <= '0;
         saved_address_ff <= '0;
         saved_length_ff  <= '0;
         resp_nibble_ff   <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         poll_count_ff    <= poll_count_in;
         saved_address_ff <= saved_address_in;
         saved_length_ff  <= saved_length_in;
         resp_nibble_ff   <= resp_nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------- buffer
   // read data register only moves on an accepted read, so it holds while stalled
   sdspi_buf #(
      .DEPTH (BLOCK_BYTES),
      .AW    (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (accept && buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (accept && buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   // ---------------------------------------------------------------- outputs
   logic [7:0] out_drive_byte;
   logic [7:0] out_fetched;

   assign out_drive_byte = rsp_ff.drive_from_buf ? buf_rdata : rsp_ff.drive_byte;
   assign out_fetched    = rsp_ff.fetch_from_buf ? buf_rdata : 8'h00;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_fetched, rsp_ff.result_status, rsp_ff.op_done,
                        rsp_ff.select_high, out_drive_byte, rsp_ff.drive_valid};

   // ---------------------------------------------------------------- checks
   a_done_no_slot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.op_done) |-> !rsp_ff.drive_valid)
      else $error("completion carries a driven slot");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.result_status != sdspi_pkg::ST_OK) |-> rsp_ff.op_done)
      else $error("status without completion");

   a_idle_exchange_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && in_op == sdspi_pkg::OP_XCHG && phase_ff == sdspi_pkg::PH_IDLE)
      |=> (!rsp_ff.drive_valid && !rsp_ff.op_done))
      else $error("exchange while idle produced activity");

   a_read_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sdspi_pkg::PH_R_DATA) |-> (byte_count_ff < saved_length_ff))
      else $error("read data count passed stored length");

   a_length_saturated: assert property (@(posedge clock) disable iff (reset)
      saved_length_ff <= BLK_CNT)
      else $error("stored read length beyond block size");

endmodule

`default_nettype wire

FILE: rtl/sdspi_buf.sv
// ============================================================================
// sdspi_buf
// Block data buffer: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module sdspi_buf #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
